// ===== rtl/core/rraem_pkg.sv =====
package rraem_pkg;

    // Module ids that the monitor watches.
    localparam logic [31:0] WATCHED_ID_A = 32'h0000_1000;
    localparam logic [31:0] WATCHED_ID_B = 32'hC000_0200;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned BACK_W     = 5;
    localparam int unsigned TIME_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_OFF_WINDOW = 3'd1,
        CFG_OFF_BACK   = 3'd2,
        CFG_ON_WINDOW  = 3'd3,
        CFG_ON_BACK    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                enable;
        logic [TIME_W-1:0]   off_window;
        logic [BACK_W-1:0]   off_back;
        logic [TIME_W-1:0]   on_window;
        logic [BACK_W-1:0]   on_back;
    } t_cfg;

endpackage

// ===== rtl/core/rraem_cfg.sv =====
module rraem_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rraem_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rraem_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rraem_pkg::t_cfg                    o_cfg
);
    import rraem_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:     r_cfg.enable     <= i_cfg_data[0];
                CFG_OFF_WINDOW: r_cfg.off_window <= i_cfg_data[TIME_W-1:0];
                CFG_OFF_BACK:   r_cfg.off_back   <= i_cfg_data[BACK_W-1:0];
                CFG_ON_WINDOW:  r_cfg.on_window  <= i_cfg_data[TIME_W-1:0];
                CFG_ON_BACK:    r_cfg.on_back    <= i_cfg_data[BACK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/rraem_ring.sv =====
module rraem_ring #(
    parameter int unsigned RING_ENTRIES = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_rd_en,
    input  logic [$clog2(RING_ENTRIES)-1:0]    i_rd_addr,
    output logic [rraem_pkg::TIME_W-1:0]       o_rd_data,
    output logic                               o_rd_valid,
    input  logic                               i_wr_en,
    input  logic [$clog2(RING_ENTRIES)-1:0]    i_wr_addr,
    input  logic [rraem_pkg::TIME_W-1:0]       i_wr_data,
    input  logic                               i_clear
);
    import rraem_pkg::*;

    logic [TIME_W-1:0]       r_mem [RING_ENTRIES];
    logic [RING_ENTRIES-1:0] r_valid;
    logic [TIME_W-1:0]       r_q;
    logic                    r_q_valid;

    // Storage array; entries without a valid bit read as empty.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read; a write or clear in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (i_rd_en) begin
            if (i_clear) begin
                r_q_valid <= 1'b0;
            end else if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_q_valid <= 1'b1;
            end else begin
                r_q_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_q <= i_wr_data;
            end else begin
                r_q <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data  = r_q;
    assign o_rd_valid = r_q_valid;

endmodule

// ===== rtl/core/reset_rate_avs_escape_monitor.sv =====
// An accepted transaction has its ring entry read in stage 1; its decision then
// goes into the output register. Throughput: one transaction per cycle while the
// output is not stalled; the ring read of an event overlaps the decision of the
// event ahead of it, whose ring write is forwarded into the read. A stalled
// output holds two transactions in flight before tready drops. Reset
// (synchronous, active low) empties the ring through per-entry valid bits, zeroes
// the write index, clears the AVS-disabled flag and all configuration registers.
module reset_rate_avs_escape_monitor #(
    parameter int unsigned RING_ENTRIES = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [rraem_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rraem_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Event stream in.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: [31:0] module_id, [63:32] now_seconds
    input  logic [63:0]                        i_s_axis_tdata,
    // tuser: [0] from_modem_core
    input  logic                               i_s_axis_tuser,
    // Result stream out.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata: [0] avs_disabled, [1] toggled, [2] counted, [7:3] zero
    output logic [7:0]                         o_m_axis_tdata
);
    import rraem_pkg::*;

    localparam int unsigned AW = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam int unsigned BACK_CODES = 2 ** BACK_W;

    t_cfg cfg;

    rraem_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Committed state that lives in flops: write index and the AVS flag.
    logic [AW-1:0]     r_wi;
    logic              r_flag;

    // Stage 1: the transaction whose ring entry is being read.
    logic              r_s1_valid;
    logic              r_s1_counted;
    logic [TIME_W-1:0] r_s1_now;

    // Output register.
    logic              r_out_valid;
    logic              r_out_avs;
    logic              r_out_tog;
    logic              r_out_cnt;

    logic              s_in_fire;
    logic              s1_adv;
    logic              in_counted;
    logic [31:0]       in_id;
    logic [TIME_W-1:0] in_now;

    // Lookback reduced modulo the ring size; built at elaboration.
    logic [AW-1:0]     back_mod_tbl [BACK_CODES];
    logic [BACK_W-1:0] back_sel;
    logic [AW-1:0]     back_mod;
    logic [AW-1:0]     wi_inc;
    logic [AW-1:0]     base_wi;
    logic [AW:0]       addr_sum;
    logic [AW-1:0]     rd_addr;

    logic [TIME_W-1:0] prev;
    logic              prev_valid;
    logic [TIME_W-1:0] window;
    logic [TIME_W-1:0] delta;
    logic              hit;
    logic              do_toggle;
    logic              do_write;

    genvar g;
    generate
        for (g = 0; g < BACK_CODES; g++) begin : g_back_mod
            assign back_mod_tbl[g] = AW'(g % RING_ENTRIES);
        end
    endgenerate

    assign in_id  = i_s_axis_tdata[31:0];
    assign in_now = i_s_axis_tdata[63:32];

    // Stage 1 moves on whenever the output register is free or being drained;
    // a new event enters exactly when stage 1 is empty or moving on.
    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign s_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    assign in_counted = cfg.enable && i_s_axis_tuser &&
                        ((in_id == WATCHED_ID_A) || (in_id == WATCHED_ID_B));

    // The look-back address is formed from the write index as it will be
    // once the event in stage 1 commits. If that event toggles, the ring is
    // cleared in the same cycle and the forwarded clear voids this read, so
    // the current flag is good enough for choosing the lookback.
    assign wi_inc   = (r_wi == AW'(RING_ENTRIES - 1)) ? '0 : r_wi + AW'(1);
    assign base_wi  = (r_s1_valid && r_s1_counted) ? wi_inc : r_wi;
    assign back_sel = r_flag ? cfg.on_back : cfg.off_back;
    assign back_mod = back_mod_tbl[back_sel];
    assign addr_sum = {1'b0, base_wi} + (AW+1)'(RING_ENTRIES) - {1'b0, back_mod};
    assign rd_addr  = (addr_sum >= (AW+1)'(RING_ENTRIES))
                    ? AW'(addr_sum - (AW+1)'(RING_ENTRIES)) : addr_sum[AW-1:0];

    // Decision for the event in stage 1. An entry that was never written
    // since the last clear reads as empty, which never matches.
    assign window    = r_flag ? cfg.on_window : cfg.off_window;
    assign delta     = r_s1_now - prev;
    assign hit       = prev_valid && (prev != '0) && (r_s1_now > prev) && (delta <= window);
    assign do_toggle = r_s1_valid && s1_adv && r_s1_counted && hit;
    assign do_write  = r_s1_valid && s1_adv && r_s1_counted && !hit;

    rraem_ring #(
        .RING_ENTRIES (RING_ENTRIES)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (s_in_fire),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (prev),
        .o_rd_valid (prev_valid),
        .i_wr_en    (do_write),
        .i_wr_addr  (r_wi),
        .i_wr_data  (r_s1_now),
        .i_clear    (do_toggle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi   <= '0;
            r_flag <= 1'b0;
        end else if (do_toggle) begin
            r_wi   <= '0;
            r_flag <= !r_flag;
        end else if (do_write) begin
            r_wi   <= wi_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_fire) begin
            r_s1_counted <= in_counted;
            r_s1_now     <= in_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // The reported flag is the value after this event.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_avs <= r_flag ^ (r_s1_counted && hit);
            r_out_tog <= r_s1_counted && hit;
            r_out_cnt <= r_s1_counted;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_cnt, r_out_tog, r_out_avs};

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rraem_pkg::*;

    localparam int unsigned RING       = 20;
    localparam int unsigned EVENTS_PER_PHASE = 184;
    // The block answers through its stage 1 and output register; the settle
    // wait covers that and any stall on the output register.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    // The receiver stops taking results once this many events have gone in.
    localparam int unsigned HOLD_AT_EVENT = 300;
    localparam int unsigned HOLD_CYCLES   = 64;

    // One exception event as the sender offers it.
    typedef struct {
        logic [31:0] module_id;
        logic        from_modem;
        logic [31:0] now_s;
    } exc_event_t;

    // What the block should report after one event.
    typedef struct {
        logic avs_disabled;
        logic toggled;
        logic counted;
    } avs_verdict_t;

    // Clock, reset and every block input start at a known value.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // tdata: [31:0] module_id, [63:32] now_seconds
    logic [63:0] i_s_axis_tdata = '0;
    // tuser: [0] from_modem_core
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // tdata: [0] avs_disabled, [1] toggled, [2] counted, [7:3] zero
    logic [7:0]  o_m_axis_tdata;

    reset_rate_avs_escape_monitor #(
        .RING_ENTRIES(RING)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    // 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Events waiting to be offered, and verdicts waiting to be seen.
    exc_event_t   pending_events[$];
    avs_verdict_t awaited_verdicts[$];

    // The predictor's own copy of the monitor: its registers, the ring of
    // earlier reset times, the write pointer and the AVS-disabled flag.
    t_cfg        monitor_cfg;
    logic [31:0] reset_ring[RING];
    int unsigned ring_wr_idx;
    logic        avs_off;

    // Knobs that the sequence in the initial block turns between phases.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned step_max    = 20;
    logic [31:0] event_clock_s = '0;

    // Bookkeeping for checks and the closing summary.
    int unsigned errors = 0;
    int unsigned events_accepted = 0;
    int unsigned verdicts_seen = 0;
    int unsigned counted_seen = 0;
    int unsigned toggles_seen = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count = 0;

    exc_event_t  offered;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    function automatic void clear_ring();
        for (int i = 0; i < RING; i++) begin
            reset_ring[i] = '0;
        end
        ring_wr_idx = 0;
    endfunction

    // Computes the verdict for one accepted event and advances the
    // predictor's state the way the block must.
    function automatic avs_verdict_t predict_avs(input exc_event_t ev);
        avs_verdict_t v;
        int unsigned  back;
        int unsigned  slot;
        logic [31:0]  window;
        logic [31:0]  prior;
        v.toggled = 1'b0;
        v.counted = 1'b0;
        if (monitor_cfg.enable && ev.from_modem &&
            (ev.module_id == WATCHED_ID_A || ev.module_id == WATCHED_ID_B)) begin
            // While AVS is on the off pair applies, while it is off the on pair.
            back   = avs_off ? monitor_cfg.on_back : monitor_cfg.off_back;
            window = avs_off ? monitor_cfg.on_window : monitor_cfg.off_window;
            // A look-back of the ring size or more wraps around the ring.
            slot   = (ring_wr_idx + RING - back % RING) % RING;
            prior  = reset_ring[slot];
            v.counted = 1'b1;
            // An empty entry, an equal time or a later one never toggles.
            if (prior != 0 && ev.now_s > prior && (ev.now_s - prior) <= window) begin
                avs_off   = ~avs_off;
                v.toggled = 1'b1;
                clear_ring();
            end else begin
                reset_ring[ring_wr_idx] = ev.now_s;
                ring_wr_idx = (ring_wr_idx + 1) % RING;
            end
        end
        v.avs_disabled = avs_off;
        return v;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Sender. A transaction completes at an edge where tvalid and tready are
    // both high; that is where the event goes into the predictor. A new event
    // is offered only once the previous one is gone, and a random share of
    // those chances is left idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                awaited_verdicts.push_back(predict_avs(offered));
                events_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_events.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    offered = pending_events.pop_front();
                    i_s_axis_tdata  <= {offered.now_s, offered.module_id};
                    i_s_axis_tuser  <= offered.from_modem;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Besides its random stalls it refuses results once for a long
    // stretch, so that the output register fills and the block stops taking
    // events while the sender keeps offering them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (!hold_done && events_accepted >= HOLD_AT_EVENT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Result checker: each result transaction is matched against the oldest
    // verdict still awaited.
    always @(posedge i_clk) begin
        avs_verdict_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            verdicts_seen++;
            if (awaited_verdicts.size() == 0) begin
                $error("result arrived with no event awaiting one: tdata %0h", o_m_axis_tdata);
                errors++;
            end else begin
                want = awaited_verdicts.pop_front();
                check_field("avs_disabled", want.avs_disabled, o_m_axis_tdata[0]);
                check_field("toggled", want.toggled, o_m_axis_tdata[1]);
                check_field("counted", want.counted, o_m_axis_tdata[2]);
            end
            if (o_m_axis_tdata[1]) toggles_seen++;
            if (o_m_axis_tdata[2]) counted_seen++;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // One register write per edge; the predictor takes the same value. Writes
    // only happen with the block idle, so no event sees a half-made change.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_ENABLE:     monitor_cfg.enable     = value[0];
            CFG_OFF_WINDOW: monitor_cfg.off_window = value;
            CFG_OFF_BACK:   monitor_cfg.off_back   = value[BACK_W-1:0];
            CFG_ON_WINDOW:  monitor_cfg.on_window  = value;
            CFG_ON_BACK:    monitor_cfg.on_back    = value[BACK_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all five registers, then an index past the list, which the block
    // must ignore.
    task automatic program_monitor(input logic en, input logic [31:0] off_win,
                                   input logic [4:0] off_back, input logic [31:0] on_win,
                                   input logic [4:0] on_back);
        write_reg(CFG_ENABLE, {31'b0, en});
        write_reg(CFG_OFF_WINDOW, off_win);
        write_reg(CFG_OFF_BACK, {27'b0, off_back});
        write_reg(CFG_ON_WINDOW, on_win);
        write_reg(CFG_ON_BACK, {27'b0, on_back});
        write_reg(CFG_ON_BACK + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Waits until every queued event is sent and every verdict has come,
    // then lets the pipeline settle before any register is touched. The
    // check is repeated after settling, since an event popped at the very
    // edge of the first check is only offered afterwards.
    task automatic wait_until_idle();
        do begin
            while (pending_events.size() != 0 || i_s_axis_tvalid ||
                   awaited_verdicts.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end while (pending_events.size() != 0 || i_s_axis_tvalid ||
                   awaited_verdicts.size() != 0);
    endtask

    task automatic offer(input logic [31:0] id, input logic modem, input logic [31:0] now_s);
        exc_event_t ev;
        ev.module_id  = id;
        ev.from_modem = modem;
        ev.now_s      = now_s;
        pending_events.push_back(ev);
    endtask

    // Random event. Most are watched resets from the modem core on a slowly
    // advancing clock, with the odd step backward, so that the look-back finds
    // recent entries and the flag flips often. The rest are filtered events
    // (other core, near-miss ids, random ids) and watched ones at random times.
    task automatic offer_random();
        int unsigned pick;
        logic [31:0] id;
        logic [31:0] now_s;
        logic        modem;
        pick  = $urandom_range(0, 99);
        id    = $urandom_range(0, 1) ? WATCHED_ID_A : WATCHED_ID_B;
        modem = 1'b1;
        now_s = $urandom;
        if (pick < 70) begin
            event_clock_s = event_clock_s + $urandom_range(0, step_max);
            if ($urandom_range(0, 19) == 0)
                event_clock_s = event_clock_s - $urandom_range(0, 2 * step_max);
            now_s = event_clock_s;
        end else if (pick < 78) begin
            modem = 1'b0;
        end else if (pick < 84) begin
            id = id ^ (32'h1 << $urandom_range(0, 31));
        end else if (pick < 90) begin
            id = $urandom;
        end
        offer(id, modem, now_s);
    endtask

    task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                    input int unsigned step);
        tx_idle_pct   = tx_pct;
        rx_idle_pct   = rx_pct;
        step_max      = step;
        event_clock_s = $urandom_range(1, 32'hFFFF_0000);
        for (int i = 0; i < EVENTS_PER_PHASE; i++) begin
            offer_random();
        end
        wait_until_idle();
    endtask

    initial begin
        monitor_cfg = '0;
        clear_ring();
        avs_off = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With reset values the monitor is off, so even
        // watched events from the modem core are not counted.
        tx_idle_pct = 17;
        rx_idle_pct = 47;
        settings_used++;
        offer(WATCHED_ID_A, 1'b1, 32'd100);
        offer(WATCHED_ID_B, 1'b1, 32'hFFFF_FFFF);
        wait_until_idle();

        program_monitor(1'b1, 32'd100, 5'd1, 32'd50, 5'd2);
        offer(WATCHED_ID_A, 1'b1, 32'd1000);   // stored
        offer(WATCHED_ID_A, 1'b1, 32'd1050);   // within the off window: AVS off
        offer(WATCHED_ID_B, 1'b1, 32'd2000);   // ring was cleared, stored
        offer(WATCHED_ID_B, 1'b1, 32'd2001);   // two back is an empty entry
        offer(WATCHED_ID_B, 1'b1, 32'd2002);   // within the on window: AVS on
        offer(WATCHED_ID_A, 1'b0, 32'd3000);   // not the modem core
        offer(32'h0000_1001, 1'b1, 32'd3000);  // near-miss id
        offer(32'h0000_0000, 1'b1, 32'd0);
        offer(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        offer(WATCHED_ID_A, 1'b1, 32'd5000);
        offer(WATCHED_ID_A, 1'b1, 32'd5000);   // same time is not earlier
        offer(WATCHED_ID_A, 1'b1, 32'd4999);   // stored entry lies later
        offer(WATCHED_ID_A, 1'b1, 32'd5100);   // just outside the window
        wait_until_idle();

        // Look-back of zero hits the entry about to be overwritten; an
        // on look-back past the ring size wraps around.
        program_monitor(1'b1, 32'hFFFF_FFFF, 5'd0, 32'd0, 5'd31);
        offer(WATCHED_ID_A, 1'b1, 32'd0);
        offer(WATCHED_ID_B, 1'b1, 32'hFFFF_FFFF);
        offer(WATCHED_ID_B, 1'b1, 32'h8000_0000);
        wait_until_idle();

        // Disabled again: everything is ignored, state stays put.
        program_monitor(1'b0, 32'd10, 5'd19, 32'd10, 5'd20);
        offer(WATCHED_ID_A, 1'b1, 32'd7000);
        wait_until_idle();

        // Random part, in three phases with different settings and idling.
        program_monitor(1'b1, 32'd40, 5'd3, 32'd25, 5'd1);
        run_random_phase(17, 47, 20);

        program_monitor(1'b1, 32'hFFFF_FFFF, 5'd19, 32'd0, 5'd0);
        run_random_phase(47, 17, 30);

        program_monitor(1'b1, $urandom_range(20, 200), 5'd31, $urandom_range(20, 200), 5'd20);
        run_random_phase(0, 0, 40);

        // Any result that shows up now has no event behind it.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        errors += awaited_verdicts.size();

        $display("Ran %0d events under %0d monitor settings, including a long output stall.",
                 events_accepted, settings_used);
        $display("Checked %0d results: %0d counted, %0d AVS state changes.",
                 verdicts_seen, counted_seen, toggles_seen);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rraem_pkg.sv
rtl/core/rraem_cfg.sv
rtl/core/rraem_ring.sv
rtl/core/reset_rate_avs_escape_monitor.sv
tb/sv/testbench.sv
